// ===== sv/mi4_pkg.sv =====
// Package for the 4x4 matrix inverse: widths, controller states, command and status structs.
// No dependencies.
`timescale 1ns / 1ps
package mi4_pkg;
  localparam int DEF_FRAC_BITS  = 16;
  localparam int DEF_DATA_WIDTH = 32;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MINOR, ST_DET, ST_DIVINIT, ST_DIV, ST_EMIT
  } state_t;

  typedef struct packed {
    logic minor_start;
    logic det_start;
    logic div_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic minor_done;
    logic det_done;
    logic div_done;
    logic singular;
  } stat_t;
endpackage

// ===== sv/mi4_ctrl.sv =====
// Controller for the matrix inverse: sequences cofactors, determinant, divisions, output.
// Depends on mi4_pkg.
`timescale 1ns / 1ps
module mi4_ctrl import mi4_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       launch,
  input  stat_t      stat,
  output cmd_t       cmd,
  output logic [3:0] idx,
  output logic       busy
);
  state_t state, state_next;
  logic [3:0] idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (launch) begin
          state_next = ST_MINOR;
          idx_next = '0;
          cmd.minor_start = 1'b1;
        end
      end
      ST_MINOR: begin
        if (stat.minor_done) begin
          if (idx == 4'd15) begin
            state_next = ST_DET;
            cmd.det_start = 1'b1;
            idx_next = '0;
          end else begin
            idx_next = idx + 4'd1;
            cmd.minor_start = 1'b1;
          end
        end
      end
      ST_DET: begin
        if (stat.det_done) state_next = ST_DIVINIT;
      end
      ST_DIVINIT: begin
        cmd.div_start = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (stat.singular || stat.div_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        idx_next = idx + 4'd1;
        state_next = (idx == 4'd15) ? ST_IDLE : ST_DIVINIT;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== sv/mi4_datapath.sv =====
// Datapath for the matrix inverse: entry store, cofactor and determinant multipliers and
// sums, restoring divider and saturation. Depends on mi4_pkg.
`timescale 1ns / 1ps
module mi4_datapath import mi4_pkg::*; #(
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [3:0]                   wr_index,
  input  logic signed [DATA_WIDTH-1:0] wr_value,
  input  cmd_t                         cmd,
  input  logic [3:0]                   idx,
  output stat_t                        stat,
  output logic [DATA_WIDTH-1:0]        res_value
);
  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;             // one product
  localparam int CW = 3 * W + 4;         // cofactor
  localparam int DW = 4 * W + 6;         // determinant
  localparam int NW = CW + 2 * FRAC_BITS; // shifted numerator
  localparam int QW = NW + 1;
  localparam int KW = $clog2(QW + 1);

  logic signed [W-1:0] store [16];
  logic signed [CW-1:0] adj [16];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) store[i] <= '0;
    end else if (wr_en) begin
      store[wr_index] <= wr_value;
    end
  end

  // cofactor of adjugate entry idx: minor omitting row idx[1:0], col idx[3:2]
  logic [1:0] rr, cc;
  assign rr = idx[1:0];
  assign cc = idx[3:2];

  function automatic logic [1:0] pick(input logic [1:0] skip, input logic [1:0] k);
    pick = (k >= skip) ? k + 2'd1 : k;
  endfunction

  // 6 terms of the 3x3 determinant: sign, and three (r,c) indices per term
  logic [2:0] step;
  logic       mbusy;
  logic signed [PW-1:0]   p1;
  logic signed [W+PW:0]   p2;
  logic signed [CW-1:0]   acc;
  logic [1:0] c0, c1, c2;
  logic       pneg;
  logic signed [W-1:0] fa, fb, fc;
  logic [1:0] r0, r1, r2;
  logic [2:0] ph;
  logic signed [W:0]   mop;
  logic signed [2*W:0] mprod;

  always_comb begin
    r0 = pick(rr, 2'd0); r1 = pick(rr, 2'd1); r2 = pick(rr, 2'd2);
    case (step)
      3'd0: begin c0 = 2'd0; c1 = 2'd1; c2 = 2'd2; pneg = 1'b0; end
      3'd1: begin c0 = 2'd0; c1 = 2'd2; c2 = 2'd1; pneg = 1'b1; end
      3'd2: begin c0 = 2'd1; c1 = 2'd0; c2 = 2'd2; pneg = 1'b1; end
      3'd3: begin c0 = 2'd1; c1 = 2'd2; c2 = 2'd0; pneg = 1'b0; end
      3'd4: begin c0 = 2'd2; c1 = 2'd0; c2 = 2'd1; pneg = 1'b0; end
      default: begin c0 = 2'd2; c1 = 2'd1; c2 = 2'd0; pneg = 1'b1; end
    endcase
    fa = store[{r0, pick(cc, c0)}];
    fb = store[{r1, pick(cc, c1)}];
    fc = store[{r2, pick(cc, c2)}];
  end

  // multiply by c one half of a*b at a time: high half first, then low half
  assign mop = (ph == 3'd1) ? (W+1)'($signed(p1[PW-1:W])) : $signed({1'b0, p1[W-1:0]});
  assign mprod = fc * mop;

  // per term: ph0 multiply a*b, ph1-ph2 multiply by c, ph3 accumulate
  logic sgn_term;
  logic signed [CW-1:0] acc_next;
  assign acc_next = sgn_term ? acc - CW'(p2) : acc + CW'(p2);

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      step  <= '0;
      ph    <= '0;
    end else if (cmd.minor_start) begin
      if (mbusy) adj[idx] <= acc_next;
      mbusy <= 1'b1;
      step  <= '0;
      ph    <= '0;
      acc   <= '0;
    end else if (mbusy) begin
      case (ph)
        3'd0: begin
          p1 <= PW'(fa * fb);
          ph <= 3'd1;
        end
        3'd1: begin
          p2 <= (W+PW+1)'(mprod);
          sgn_term <= pneg ^ (rr[0] ^ cc[0]);
          ph <= 3'd2;
        end
        3'd2: begin
          p2 <= (p2 <<< W) + (W+PW+1)'(mprod);
          ph <= 3'd3;
        end
        default: begin
          acc <= acc_next;
          ph  <= 3'd0;
          if (step == 3'd5) begin
            mbusy <= 1'b0;
            adj[idx] <= acc_next;
          end else begin
            step <= step + 3'd1;
          end
        end
      endcase
    end
  end
  assign stat.minor_done = mbusy && (ph == 3'd3) && (step == 3'd5);

  // determinant = sum e[j] * adj[j*4], cofactor taken in four slices, top first
  localparam int HW = (CW + 3) / 4;
  logic [2:0] dj;
  logic [2:0] dph;
  logic       dbusy;
  logic signed [DW-1:0] det;
  logic signed [DW-1:0] dterm;
  logic signed [W-1:0]  de;
  logic signed [CW-1:0] da;
  logic signed [HW:0]   dslice;
  logic signed [W+HW:0] dprod;
  assign de = store[{2'd0, dj[1:0]}];
  assign da = adj[{dj[1:0], 2'd0}];

  always_comb begin
    case (dph)
      3'd0: dslice = (HW+1)'($signed(da[CW-1:3*HW]));
      3'd1: dslice = $signed({1'b0, da[3*HW-1:2*HW]});
      3'd2: dslice = $signed({1'b0, da[2*HW-1:HW]});
      default: dslice = $signed({1'b0, da[HW-1:0]});
    endcase
  end
  assign dprod = de * dslice;

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dj    <= '0;
      dph   <= '0;
    end else if (cmd.det_start) begin
      dbusy <= 1'b1;
      dj <= '0;
      dph <= '0;
      det <= '0;
    end else if (dbusy) begin
      case (dph)
        3'd0: begin
          dterm <= DW'(dprod);
          dph <= 3'd1;
        end
        3'd4: begin
          det <= det + dterm;
          dph <= 3'd0;
          if (dj == 3'd3) dbusy <= 1'b0;
          else dj <= dj + 3'd1;
        end
        default: begin
          dterm <= (dterm <<< HW) + DW'(dprod);
          dph <= dph + 3'd1;
        end
      endcase
    end
  end
  assign stat.det_done = dbusy && (dph == 3'd4) && (dj == 3'd3);
  assign stat.singular = (det == '0);

  // restoring division, one quotient bit per cycle
  logic [NW-1:0] na;
  logic [DW-1:0] dd;
  logic [DW:0]   rem;
  logic [QW-1:0] q;
  logic [KW-1:0] kc;
  logic          qneg, vbusy;
  logic signed [CW-1:0] cur;
  logic [DW:0] trial;
  assign cur = adj[idx];
  assign trial = {rem[DW-1:0], na[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vbusy <= 1'b0;
      kc <= '0;
    end else if (cmd.div_start) begin
      vbusy <= 1'b1;
      kc <= KW'(NW);
      na <= NW'(cur[CW-1] ? -cur : cur) << (2 * FRAC_BITS);
      dd <= det[DW-1] ? DW'(-det) : DW'(det);
      qneg <= cur[CW-1] ^ det[DW-1];
      rem <= '0;
      q <= '0;
    end else if (vbusy) begin
      na <= na << 1;
      if (trial >= {1'b0, dd}) begin
        rem <= trial - {1'b0, dd};
        q <= {q[QW-2:0], 1'b1};
      end else begin
        rem <= trial;
        q <= {q[QW-2:0], 1'b0};
      end
      kc <= kc - KW'(1);
      if (kc == KW'(1)) vbusy <= 1'b0;
    end
  end
  assign stat.div_done = vbusy && (kc == KW'(1)) ? 1'b0 : (!vbusy && !cmd.div_start);

  localparam logic [QW-1:0] LIM = QW'(1) << (W - 1);
  always_comb begin
    if (stat.singular) res_value = '0;
    else if (qneg) res_value = (q > LIM) ? W'(-LIM) : W'(-q);
    else res_value = (q > LIM - QW'(1)) ? W'(LIM - QW'(1)) : W'(q);
  end
endmodule

// ===== sv/matrix_inverse_4x4.sv =====
// 4x4 matrix inverse, adjugate method. A go transaction starts 16 cofactors and a
// determinant, then one restoring division per result, cut short when singular;
// start is refused while busy. Results are strobed one at a time and cannot be stalled.
// Synchronous reset clears the controller and the entry store to zero.
`timescale 1ns / 1ps
module matrix_inverse_4x4 import mi4_pkg::*; #(
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [3:0]                   entry_index,
  input  logic signed [DATA_WIDTH-1:0] entry_value,
  input  logic                         go,
  output logic                         strobe,
  output logic [3:0]                   out_index,
  output logic signed [DATA_WIDTH-1:0] out_value,
  output logic                         singular,
  output logic                         run_last
);
  cmd_t  cmd;
  stat_t stat;
  logic [3:0] idx;
  logic [DATA_WIDTH-1:0] res_value;
  logic acc;
  assign acc = start && !busy;

  mi4_ctrl u_ctrl (
    .clk(clk), .rst(rst), .launch(acc && go), .stat(stat),
    .cmd(cmd), .idx(idx), .busy(busy)
  );

  mi4_datapath #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .wr_en(acc), .wr_index(entry_index),
    .wr_value(entry_value), .cmd(cmd), .idx(idx), .stat(stat),
    .res_value(res_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_index <= idx;
      out_value <= $signed(res_value);
      singular  <= stat.singular;
      run_last  <= (idx == 4'd15);
    end
  end
endmodule
